// ----- rtl/core/sm3_pkg.sv -----
package sm3_pkg;

  localparam int BlkBytes = 64;
  localparam int BlkAw    = 6;
  localparam int WinDepth = 16;
  localparam int WinAw    = 4;

  localparam logic [31:0] TjLow  = 32'h79cc4519;
  localparam logic [31:0] TjHigh = 32'h7a879d8a;
  localparam logic [7:0]  PadByte = 8'h80;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } sm3_state_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] w;
    unique case (idx)
      3'd0: w = 32'h7380166f;
      3'd1: w = 32'h4914b2b9;
      3'd2: w = 32'h172442d7;
      3'd3: w = 32'hda8a0600;
      3'd4: w = 32'ha96f30bc;
      3'd5: w = 32'h163138aa;
      3'd6: w = 32'he38dee4d;
      default: w = 32'hb0fb0e4e;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
  endfunction

endpackage

// ----- rtl/core/sm3_hash_engine.sv -----
// SM3 hash engine.
// Input stream: one beat per message byte. in_tdata carries data_byte,
// in_tuser = byte_present, in_tlast = end_of_message. A beat with
// byte_present 0 and tlast 1 closes the message without adding a byte.
// Output stream: eight beats per message, digest word 0 first; out_tdata
// carries digest_word, out_tuser word_index, out_tlast marks word 7.
// Bytes are written to a 64x8 block RAM, one per accepted beat with byte_present set.
// A full block runs the compression: the 16-word expansion window RAM
// is loaded from the block RAM, then 64 rounds follow (the window RAM
// gives one read per cycle, six words per round), and a last step
// folds the working state into the chaining value.
// Closing a message adds padding writes (one per remaining byte of
// each padded block, up to 72 in all), one or two compressions and
// 8 output beats. The input is held off while padding, while a block
// is compressed or while the digest is sent; a stall on the output simply
// holds the current digest beat. Reset restores the IV and clears the
// byte and bit counters; no RAM clearing is needed.
module sm3_hash_engine
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // digest_last
);

  sm3_state_t state_r, state_nxt;
  logic [BlkAw:0]   fill_r, fill_nxt;
  logic [63:0]      bits_r, bits_nxt;
  logic             fin_r, fin_nxt;     // message closing: pad path
  logic             twoblk_r, twoblk_nxt;
  logic [6:0]       cnt_r, cnt_nxt;     // load / round counter
  logic [1:0]       ph_r, ph_nxt;       // read phase within a round
  logic [31:0]      cv_r [8];
  logic [31:0]      cv_nxt [8];
  logic [31:0]      v_r [8];
  logic [31:0]      v_nxt [8];
  logic [31:0]      wj_r, wj_nxt, w4_r, w4_nxt, w7_r, w7_nxt, w13_r, w13_nxt;
  logic [31:0]      w3_r, w3_nxt;
  logic [31:0]      word_r, word_nxt;   // byte assembly during load
  logic [2:0]       oidx_r, oidx_nxt;

  logic             b_we;
  logic [BlkAw-1:0] b_wa, b_ra;
  logic [7:0]       b_wd, b_rd;
  logic             w_we;
  logic [WinAw-1:0] w_wa, w_ra;
  logic [31:0]      w_wd, w_rd;

  sm3_ram #(.Width(8), .Depth(BlkBytes)) u_blk (
    .clk(clk), .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd),
    .rd_addr(b_ra), .rd_data(b_rd)
  );

  sm3_ram #(.Width(32), .Depth(WinDepth)) u_win (
    .clk(clk), .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd),
    .rd_addr(w_ra), .rd_data(w_rd)
  );

  logic [5:0]  rj;
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, wn;
  logic [7:0]  len_byte;

  assign rj = cnt_r[5:0];

  always_comb begin
    tj  = (rj < 6'd16) ? TjLow : TjHigh;
    a12 = rol(v_r[0], 5'd12);
    ss1 = rol(a12 + v_r[4] + rol(tj, rj[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (rj < 6'd16) begin
      ff = v_r[0] ^ v_r[1] ^ v_r[2];
      gg = v_r[4] ^ v_r[5] ^ v_r[6];
    end else begin
      ff = (v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]);
      gg = (v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]);
    end
    tt1 = ff + v_r[3] + ss2 + (wj_r ^ w4_r);
    tt2 = gg + v_r[7] + ss1 + wj_r;
    // w_rd holds W(j+10) in the last phase
    wn  = perm1(wj_r ^ w7_r ^ rol(w13_r, 5'd15)) ^ rol(w3_r, 5'd7) ^ w_rd;
    len_byte = bits_r[63 - 8*fill_r[2:0] -: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      bits_r   <= '0;
      fin_r    <= 1'b0;
      twoblk_r <= 1'b0;
      cnt_r    <= '0;
      ph_r     <= '0;
      oidx_r   <= '0;
      for (int i = 0; i < 8; i++) cv_r[i] <= iv_word(3'(i));
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      bits_r   <= bits_nxt;
      fin_r    <= fin_nxt;
      twoblk_r <= twoblk_nxt;
      cnt_r    <= cnt_nxt;
      ph_r     <= ph_nxt;
      oidx_r   <= oidx_nxt;
      for (int i = 0; i < 8; i++) cv_r[i] <= cv_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) v_r[i] <= v_nxt[i];
    wj_r   <= wj_nxt;
    w4_r   <= w4_nxt;
    w7_r   <= w7_nxt;
    w13_r  <= w13_nxt;
    w3_r   <= w3_nxt;
    word_r <= word_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    bits_nxt   = bits_r;
    fin_nxt    = fin_r;
    twoblk_nxt = twoblk_r;
    cnt_nxt    = cnt_r;
    ph_nxt     = ph_r;
    oidx_nxt   = oidx_r;
    cv_nxt     = cv_r;
    v_nxt      = v_r;
    wj_nxt     = wj_r;
    w4_nxt     = w4_r;
    w7_nxt     = w7_r;
    w13_nxt    = w13_r;
    w3_nxt     = w3_r;
    word_nxt   = word_r;
    b_we = 1'b0;
    b_wa = fill_r[BlkAw-1:0];
    b_wd = in_tdata;
    b_ra = '0;
    w_we = 1'b0;
    w_wa = '0;
    w_wd = '0;
    w_ra = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser) begin
            b_we = 1'b1;
            fill_nxt = fill_r + 1'b1;
            bits_nxt = bits_r + 64'd8;
          end
          fin_nxt = in_tlast;
          if (in_tuser && fill_r == 7'd63) begin
            state_nxt = ST_LOAD;
            cnt_nxt = '0;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
            twoblk_nxt = 1'b0;
          end
        end
      end
      ST_PAD: begin
        // 0x80 first, then zeros up to the length field or block end
        b_we = 1'b1;
        b_wd = (fin_r && !twoblk_r) ? PadByte : 8'h00;
        if (fin_r && !twoblk_r) twoblk_nxt = 1'b1;
        fill_nxt = fill_r + 1'b1;
        if (fill_r == 7'd63) begin
          state_nxt = ST_LOAD;
          cnt_nxt = '0;
        end else if (fill_r == 7'd55 && !(fin_r && !twoblk_r) ? 1'b1 :
                     (fill_r == 7'd55 && fin_r && !twoblk_r)) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        b_we = 1'b1;
        b_wd = len_byte;
        fill_nxt = fill_r + 1'b1;
        if (fill_r == 7'd63) begin
          state_nxt = ST_LOAD;
          fin_nxt = 1'b0;
          cnt_nxt = '0;
        end
      end
      ST_LOAD: begin
        // one byte read per cycle, words written to the window RAM
        b_ra = cnt_r[BlkAw-1:0];
        if (cnt_r != 7'd0) begin
          word_nxt = {word_r[23:0], b_rd};
          if (cnt_r[1:0] == 2'd0) begin
            w_we = 1'b1;
            w_wa = 4'(cnt_r[5:2] - 4'd1);
            w_wd = {word_r[23:0], b_rd};
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 7'd64) begin
          w_wa = 4'd15;
          state_nxt = ST_ROUND;
          cnt_nxt = '0;
          ph_nxt = '0;
          v_nxt = cv_r;
        end
      end
      ST_ROUND: begin
        // phases read W(j), W(j+4), W(j+7) and W(j+13)
        unique case (ph_r)
          2'd0: w_ra = rj[3:0];
          2'd1: begin
            w_ra = 4'(rj[3:0] + 4'd4);
            wj_nxt = w_rd;
          end
          2'd2: begin
            w_ra = 4'(rj[3:0] + 4'd7);
            w4_nxt = w_rd;
          end
          default: begin
            w_ra = 4'(rj[3:0] + 4'd13);
            w7_nxt = w_rd;
          end
        endcase
        ph_nxt = ph_r + 1'b1;
        if (ph_r == 2'd3) begin
          state_nxt = ST_FOLD;
          cnt_nxt = cnt_r;
        end
      end
      ST_FOLD: begin
        // extra reads: W(j+13) arrives, then W(j+3), then W(j+10); then the round update and the W(j+16) write
        unique case (ph_r)
          2'd0: begin
            w13_nxt = w_rd;
            w_ra = 4'(rj[3:0] + 4'd3);
            ph_nxt = 2'd1;
          end
          2'd1: begin
            w3_nxt = w_rd;
            w_ra = 4'(rj[3:0] + 4'd10);
            ph_nxt = 2'd2;
          end
          2'd2: begin
            w_ra = 4'(rj[3:0] + 4'd10);
            ph_nxt = 2'd3;
          end
          default: begin
            w_we = 1'b1;
            w_wa = rj[3:0];
            w_wd = wn;
            v_nxt[3] = v_r[2];
            v_nxt[2] = rol(v_r[1], 5'd9);
            v_nxt[1] = v_r[0];
            v_nxt[0] = tt1;
            v_nxt[7] = v_r[6];
            v_nxt[6] = rol(v_r[5], 5'd19);
            v_nxt[5] = v_r[4];
            v_nxt[4] = perm0(tt2);
            ph_nxt = 2'd0;
            cnt_nxt = cnt_r + 1'b1;
            if (cnt_r == 7'd63) begin
              state_nxt = ST_EMIT;
              oidx_nxt = '0;
              cnt_nxt = '0;
            end else begin
              state_nxt = ST_ROUND;
            end
          end
        endcase
      end
      ST_EMIT: begin
        // first pass folds; after the last block, send the digest
        if (cnt_r == 7'd0) begin
          for (int i = 0; i < 8; i++) cv_nxt[i] = cv_r[i] ^ v_r[i];
          cnt_nxt = 7'd1;
          fill_nxt = '0;
          if (fin_r || twoblk_r) begin
            if (fin_r) begin
              state_nxt = ST_PAD;
            end
          end else if (!fin_r && !twoblk_r) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          out_tvalid = 1'b1;
          if (out_tready) begin
            oidx_nxt = oidx_r + 1'b1;
            if (oidx_r == 3'd7) begin
              state_nxt = ST_IDLE;
              for (int i = 0; i < 8; i++) cv_nxt[i] = iv_word(3'(i));
              fill_nxt = '0;
              bits_nxt = '0;
              twoblk_nxt = 1'b0;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tdata = cv_r[oidx_r];
  assign out_tuser = oidx_r;
  assign out_tlast = (oidx_r == 3'd7);

  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == ST_EMIT) else $error("output outside emit");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output overlap");
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (fill_r == '0 && bits_r == '0))
    else $error("counters not cleared after digest");

endmodule

// ----- rtl/core/sm3_ram.sv -----
module sm3_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- verif/sm3_hash_engine_tb.sv -----
module sm3_hash_engine_tb
  import sm3_pkg::*;
();

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // byte_present
  logic        in_tlast;   // end_of_message
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] digest_word
  logic [2:0]  out_tuser;  // [2:0] word_index
  logic        out_tlast;  // digest_last

  // predictor state
  logic [31:0] chain[8];
  logic [7:0]  blk[64];
  int unsigned fill;
  logic [63:0] msg_bits;

  digest_beat_t digest_q[$];
  int          mismatches;
  int          beats_seen;
  int          msgs_sent;
  int          bytes_sent;
  int          idle_cycles;
  bit          timed_out;
  bit          stim_done;
  int          burst_left;

  localparam int WatchdogLimit = 20000;

  sm3_hash_engine dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w[68];
    logic [31:0] v[8];
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 68; i++) begin
      tt1 = w[i-16] ^ w[i-9] ^ rotl(w[i-3], 15);
      w[i] = (tt1 ^ rotl(tt1, 15) ^ rotl(tt1, 23)) ^ rotl(w[i-13], 7) ^ w[i-6];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int j = 0; j < 64; j++) begin
      tj = (j < 16) ? TjLow : TjHigh;
      a12 = rotl(v[0], 12);
      ss1 = rotl(a12 + v[4] + rotl(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = v[0] ^ v[1] ^ v[2];
        gg = v[4] ^ v[5] ^ v[6];
      end else begin
        ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
        gg = (v[4] & v[5]) | (~v[4] & v[6]);
      end
      tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + v[7] + ss1 + w[j];
      v[3] = v[2];
      v[2] = rotl(v[1], 9);
      v[1] = v[0];
      v[0] = tt1;
      v[7] = v[6];
      v[6] = rotl(v[5], 19);
      v[5] = v[4];
      v[4] = tt2 ^ rotl(tt2, 9) ^ rotl(tt2, 17);
    end
    for (int i = 0; i < 8; i++) chain[i] ^= v[i];
  endtask

  task automatic restart_digest();
    for (int i = 0; i < 8; i++) chain[i] = iv_word(3'(i));
    fill = 0;
    msg_bits = '0;
  endtask

  task automatic predict_beat(input logic [7:0] b, input logic present, input logic eom);
    digest_beat_t nb;
    if (present) begin
      blk[fill] = b;
      fill = (fill + 1) % 64;
      msg_bits += 64'd8;
      if (fill == 0) compress();
    end
    if (eom) begin
      blk[fill] = PadByte;
      fill++;
      if (fill > 56) begin
        for (int i = fill; i < 64; i++) blk[i] = '0;
        compress();
        fill = 0;
      end
      for (int i = fill; i < 56; i++) blk[i] = '0;
      for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        nb = {chain[i], 3'(i), (i == 7)};
        digest_q.insert(digest_q.size(), nb);
      end
      restart_digest();
    end
  endtask

  // Drive one beat with bursty gaps, then predict on acceptance.
  task automatic send_beat(input logic [7:0] b, input logic present, input logic eom);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= present;
    in_tlast  <= eom;
    do @(posedge clk); while (!(in_tready));
    predict_beat(b, present, eom);
    if (present) bytes_sent++;
    if (eom) msgs_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_message(input int len, input logic trailing_empty);
    for (int i = 0; i < len; i++)
      send_beat(8'($urandom), 1'b1, (i == len - 1) && !trailing_empty);
    if (trailing_empty || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_empty_message();
    send_message(0, 1'b1);
  endtask

  task automatic test_known_abc();
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
  endtask

  task automatic test_extreme_bytes();
    // all-ones then all-zeros bytes; ignored byte on the closing beat
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b1);
  endtask

  task automatic test_padding_boundaries();
    // lengths where padding spills into a second block or fills one exactly
    int lens[6] = '{55, 56, 63, 64, 65, 119};
    foreach (lens[k]) send_message(lens[k], 1'(lens[k] % 2));
  endtask

  task automatic test_random_messages();
    int len;
    while (bytes_sent < 500) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(120, 200);
        1, 2: len = 0;
        default: len = $urandom_range(1, 20);
      endcase
      // empty-byte beats ahead of a message are pure noise to the block
      if (len > 0 && $urandom_range(0, 3) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_message(len, 1'($urandom_range(0, 1)));
    end
  endtask

  // output stall pattern: ready drawn at random each cycle, mostly high
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (($urandom_range(0, 63) < 16)) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    digest_beat_t exp_b;
    if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest beat %h idx %0d", out_tdata, out_tuser);
      end else begin
        exp_b = digest_q.pop_front();
        if (out_tdata !== exp_b.word || out_tuser !== exp_b.idx || out_tlast !== exp_b.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b", exp_b.word, exp_b.idx,
                     exp_b.last, out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else if (rst_n && (!stim_done || digest_q.size() != 0)) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) timed_out <= 1'b1;
  end

  always @(posedge timed_out) begin
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    mismatches = 0;
    beats_seen = 0;
    msgs_sent = 0;
    bytes_sent = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    stim_done = 1'b0;
    burst_left = 0;
    restart_digest();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_empty_message();
    test_known_abc();
    test_extreme_bytes();
    test_padding_boundaries();
    test_random_messages();
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Hashed %0d messages, %0d bytes; checked %0d digest beats.",
             msgs_sent, bytes_sent, beats_seen);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
